// ===== rtl/core/projection_profile_segmenter_top_assert.svh =====
// assertion helpers for the projection profile segmenter
`ifndef PROJECTION_PROFILE_SEGMENTER_TOP_ASSERT_SVH
`define PROJECTION_PROFILE_SEGMENTER_TOP_ASSERT_SVH

// same-cycle implication
`define PPSEG_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("ppseg assertion failed");

// next-cycle implication
`define PPSEG_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("ppseg assertion failed");

`endif

// ===== rtl/core/ppseg_pkg.sv =====
package ppseg_pkg;

    localparam int unsigned MAX_LINE_LEN = 4096;
    localparam int unsigned MAX_LINES    = 4096;

    // saturation limits of the line counters
    localparam logic [12:0] CNT_CAP =
        (MAX_LINE_LEN < 8191) ? 13'(MAX_LINE_LEN) : 13'd8191;
    localparam logic [11:0] IDX_CAP =
        ((MAX_LINES - 1) < 4095) ? 12'(MAX_LINES - 1) : 12'd4095;

    localparam logic [12:0] RST_MIN_LINE_COUNT = 13'd5;
    localparam logic [23:0] RST_MIN_RUN_MASS   = 24'd80;
    localparam logic [7:0]  RST_MARGIN         = 8'd10;
    localparam logic [12:0] RST_LINE_TOTAL     = 13'd4096;

    localparam logic [12:0] LINE_TOTAL_MAX = 13'd4096;
    localparam logic [23:0] MASS_MAX       = 24'hFFFFFF;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [7:0] {
        REG_MIN_LINE_COUNT = 8'd0,
        REG_MIN_RUN_MASS   = 8'd1,
        REG_MARGIN         = 8'd2,
        REG_LINE_TOTAL     = 8'd3
    } t_reg_idx;

    typedef struct packed {
        logic [12:0] min_line_count;
        logic [23:0] min_run_mass;
        logic [7:0]  margin;
        logic [12:0] line_total;
    } t_cfg;

    // a closed run waiting for the segment stage
    typedef struct packed {
        logic [11:0] first_line;
        logic [11:0] last_line;
        logic [23:0] mass;
    } t_event;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/core/ppseg_front.sv =====
module ppseg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppseg_pkg::t_cfg   i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_pixel,
    input  logic              i_line_end,
    input  logic              i_image_end,
    input  ppseg_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output ppseg_pkg::t_event o_event
);
    import ppseg_pkg::*;

    logic [12:0] r_dark_count, n_dark_count;
    logic [11:0] r_line_index, n_line_index;
    logic [23:0] r_run_mass, n_run_mass;
    logic        r_run_active, n_run_active;
    logic [11:0] r_run_first, n_run_first;

    logic        accept;
    logic [12:0] dc_inc;
    logic [12:0] line_cnt;
    logic [24:0] mass_sum;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_dark_count = r_dark_count;
        n_line_index = r_line_index;
        n_run_mass   = r_run_mass;
        n_run_active = r_run_active;
        n_run_first  = r_run_first;
        o_push       = 1'b0;
        o_event      = '{first_line: r_run_first, last_line: r_line_index, mass: r_run_mass};

        dc_inc = r_dark_count;
        if (i_pixel == 8'd0 && r_dark_count < CNT_CAP) begin
            dc_inc = r_dark_count + 13'd1;
        end
        line_cnt = (dc_inc < i_cfg.min_line_count) ? 13'd0 : dc_inc;
        mass_sum = {1'b0, r_run_mass} + {12'd0, line_cnt};

        if (accept) begin
            n_dark_count = dc_inc;
            if (i_line_end || i_image_end) begin
                if (line_cnt != 13'd0) begin
                    if (!r_run_active) begin
                        n_run_active = 1'b1;
                        n_run_first  = r_line_index;
                        n_run_mass   = {11'd0, line_cnt};
                    end else begin
                        n_run_mass = mass_sum[24] ? MASS_MAX : mass_sum[23:0];
                    end
                    if (i_image_end) begin
                        // run closes on this line
                        o_push  = 1'b1;
                        o_event = '{first_line: n_run_first, last_line: r_line_index,
                                    mass: n_run_mass};
                    end
                end else if (r_run_active) begin
                    // empty line ends the run at the previous line
                    o_push       = 1'b1;
                    n_run_active = 1'b0;
                    o_event.last_line = (r_line_index != 12'd0) ?
                                        r_line_index - 12'd1 : 12'd0;
                end
                n_dark_count = 13'd0;
                if (i_image_end) begin
                    n_line_index = 12'd0;
                    n_run_active = 1'b0;
                    n_run_mass   = 24'd0;
                    n_run_first  = 12'd0;
                end else if (r_line_index < IDX_CAP) begin
                    n_line_index = r_line_index + 12'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_count <= 13'd0;
            r_line_index <= 12'd0;
            r_run_mass   <= 24'd0;
            r_run_active <= 1'b0;
            r_run_first  <= 12'd0;
        end else begin
            r_dark_count <= n_dark_count;
            r_line_index <= n_line_index;
            r_run_mass   <= n_run_mass;
            r_run_active <= n_run_active;
            r_run_first  <= n_run_first;
        end
    end

endmodule

// ===== rtl/core/ppseg_queue.sv =====
module ppseg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ppseg_pkg::t_event  i_event,
    input  logic               i_pop,
    output ppseg_pkg::t_event  o_head,
    output ppseg_pkg::t_q_stat o_stat
);
    import ppseg_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_event             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]     r_count, n_count;
    logic               do_push, do_pop;

    assign o_stat.full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (PTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/core/ppseg_back.sv =====
module ppseg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppseg_pkg::t_cfg    i_cfg,
    input  ppseg_pkg::t_q_stat i_q_stat,
    input  ppseg_pkg::t_event  i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [11:0]        o_start,
    output logic [11:0]        o_finish
);
    import ppseg_pkg::*;

    logic        r_valid, n_valid;
    logic [11:0] r_start, r_finish;

    logic        emit;
    logic [11:0] prev_line;
    logic [11:0] margin_ext;
    logic [11:0] seg_start;
    logic [12:0] lt_clamped;
    logic [11:0] limit;
    logic [12:0] fin_sum;
    logic [11:0] seg_finish;

    assign o_pop = !i_q_stat.empty && (!r_valid || i_ready);

    always_comb begin
        emit       = i_head.mass > i_cfg.min_run_mass;
        margin_ext = {4'd0, i_cfg.margin};
        prev_line  = i_head.first_line - 12'd1;
        if (i_head.first_line == 12'd0) begin
            seg_start = 12'd0;
        end else if (prev_line > margin_ext) begin
            seg_start = prev_line - margin_ext;
        end else begin
            seg_start = 12'd0;
        end

        if (i_cfg.line_total == 13'd0) begin
            lt_clamped = 13'd1;
        end else if (i_cfg.line_total > LINE_TOTAL_MAX) begin
            lt_clamped = LINE_TOTAL_MAX;
        end else begin
            lt_clamped = i_cfg.line_total;
        end
        limit      = 12'(lt_clamped - 13'd1);
        fin_sum    = {1'b0, i_head.last_line} + {5'd0, i_cfg.margin};
        seg_finish = (fin_sum > {1'b0, limit}) ? limit : fin_sum[11:0];

        n_valid = (r_valid && !i_ready) || (o_pop && emit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_start  <= seg_start;
            r_finish <= seg_finish;
        end
    end

    assign o_valid  = r_valid;
    assign o_start  = r_start;
    assign o_finish = r_finish;

endmodule

// ===== rtl/core/projection_profile_segmenter_top.sv =====
// projection profile segmenter
// s_axis carries pixels one per transaction, line by line: tdata is the pixel
// (0 is dark), tlast marks the last pixel of a line and tuser the last pixel
// of the image. m_axis carries one transaction per segment found, with the
// first and last line of the segment, margins included.
// cfg writes one register per transaction (0 min line count, 1 min run mass,
// 2 margin, 3 line total); write only while the block is idle.
// throughput: one pixel per cycle while the queue has room. the line counters
// update in the cycle a pixel is taken; a closed run goes into a 4-entry queue
// and the segment stage pops it into the registered result on m_axis, or
// drops it when its mass does not exceed the min run mass.
// when m_axis stalls the result register holds, the queue fills, and
// s_axis_tready drops only once all 4 queue entries are taken.
// reset clears counters, run state, queue and output valid, and restores
// the register defaults (5, 80, 10, 4096).
module projection_profile_segmenter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic        s_axis_tlast,   // line_end
    input  logic        s_axis_tuser,   // [0] image_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [11:0] seg_start, [23:12] seg_finish
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ppseg_pkg::*;

    `include "projection_profile_segmenter_top_assert.svh"

    t_cfg    r_cfg;
    t_q_stat q_stat;
    t_event  push_event;
    t_event  head_event;
    logic    q_push;
    logic    q_pop;
    logic [11:0] seg_start;
    logic [11:0] seg_finish;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_line_count <= RST_MIN_LINE_COUNT;
            r_cfg.min_run_mass   <= RST_MIN_RUN_MASS;
            r_cfg.margin         <= RST_MARGIN;
            r_cfg.line_total     <= RST_LINE_TOTAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MIN_LINE_COUNT: r_cfg.min_line_count <= i_cfg_data[12:0];
                REG_MIN_RUN_MASS:   r_cfg.min_run_mass   <= i_cfg_data[23:0];
                REG_MARGIN:         r_cfg.margin         <= i_cfg_data[7:0];
                REG_LINE_TOTAL:     r_cfg.line_total     <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    ppseg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_pixel     (s_axis_tdata),
        .i_line_end  (s_axis_tlast),
        .i_image_end (s_axis_tuser),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_event     (push_event)
    );

    ppseg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_event (push_event),
        .i_pop   (q_pop),
        .o_head  (head_event),
        .o_stat  (q_stat)
    );

    ppseg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .i_head   (head_event),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_start  (seg_start),
        .o_finish (seg_finish)
    );

    assign m_axis_tdata = {seg_finish, seg_start};

    // a closed run is never dropped at a full queue
    `PPSEG_ASSERT_NOW(a_no_push_when_full, i_clk, !i_rst_n, q_push, !q_stat.full)

    // a new result only follows a pop from the queue
    `PPSEG_ASSERT_NOW(a_result_from_pop, i_clk, !i_rst_n, $rose(m_axis_tvalid), $past(q_pop))

    // the segment stage never pops an empty queue
    `PPSEG_ASSERT_NOW(a_pop_not_empty, i_clk, !i_rst_n, q_pop, !q_stat.empty)

    // reset leaves no result pending
    `PPSEG_ASSERT_NEXT(a_reset_clears_out, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid)

endmodule

// ===== tb/projection_profile_segmenter_top_tb.sv =====
module projection_profile_segmenter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppseg_pkg::*;

    typedef struct packed {
        logic [11:0] first_line;
        logic [11:0] last_line;
    } t_seg;

    // one directed pixel; typed rows carry the segment they must close
    typedef struct packed {
        logic [7:0]  pix;
        logic        lend;
        logic        iend;
        logic        typed;
        logic [11:0] first_line;
        logic [11:0] last_line;
    } t_row;

    typedef struct packed {
        logic [12:0] min_line;
        logic [23:0] min_mass;
        logic [7:0]  margin;
        logic [12:0] lines;
        logic [7:0]  max_lines;
        logic [7:0]  max_len;
    } t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] pixel
    logic        s_axis_tlast;   // line_end
    logic        s_axis_tuser;   // [0] image_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [11:0] seg_start, [23:12] seg_finish
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    projection_profile_segmenter_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // profile state and register copies
    logic [12:0] cfg_min_line = RST_MIN_LINE_COUNT;
    logic [23:0] cfg_min_mass = RST_MIN_RUN_MASS;
    logic [7:0]  cfg_margin   = RST_MARGIN;
    logic [12:0] cfg_lines    = RST_LINE_TOTAL;
    logic [12:0] dark_cnt     = '0;
    logic [11:0] line_idx     = '0;
    logic [23:0] run_mass     = '0;
    logic        run_on       = 1'b0;
    logic [11:0] run_first    = '0;

    t_seg segs_due[$];
    t_seg no_seg = '0;
    int   errors = 0;
    int   pixels_sent = 0;
    int   segs_checked = 0;
    bit   calm = 1'b0;

    // config for the directed rows: min line 1, min mass 1, margin 1, 5 lines
    t_row plan [17] = '{
        '{8'h00, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 12'd0, 12'd2},   // run from line 0 closes
        '{8'h00, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h5A, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0},   // mass not above threshold
        '{8'h00, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h00, 1'b1, 1'b1, 1'b1, 12'd3, 12'd4},   // closes on image end, clamped
        '{8'h00, 1'b0, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h01, 1'b0, 1'b1, 1'b1, 12'd0, 12'd1},   // empty line ending the image
        '{8'hFF, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 12'd0, 12'd4},   // image end without line end
        '{8'h7F, 1'b1, 1'b1, 1'b0, 12'd0, 12'd0}
    };

    t_phase phases [7] = '{
        '{13'd2,    24'd4,        8'd1,   13'd8,    8'd12, 8'd6},
        '{13'd0,    24'd0,        8'd0,   13'd4096, 8'd10, 8'd4},
        '{13'd1,    24'd10,       8'd255, 13'd100,  8'd14, 8'd5},
        '{13'd3,    24'hFFFFFF,   8'd7,   13'd1,    8'd8,  8'd6},
        '{13'd1,    24'd2,        8'd4,   13'd0,    8'd10, 8'd4},
        '{13'd5,    24'd80,       8'd10,  13'd4096, 8'd12, 8'd20},
        '{13'd1,    24'd3,        8'd2,   13'd8191, 8'd10, 8'd5}
    };

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic bit close_segment(input logic [11:0] last, output t_seg seg);
        int prev;
        int lim;
        int fin;
        bit hit;
        seg = '0;
        hit = run_mass > cfg_min_mass;
        if (hit) begin
            if (run_first == 12'd0) begin
                seg.first_line = 12'd0;
            end else begin
                prev = int'(run_first) - 1;
                seg.first_line = (prev > int'(cfg_margin)) ?
                                 12'(prev - int'(cfg_margin)) : 12'd0;
            end
            if (cfg_lines == 13'd0)
                lim = 0;
            else if (cfg_lines > LINE_TOTAL_MAX)
                lim = int'(LINE_TOTAL_MAX) - 1;
            else
                lim = int'(cfg_lines) - 1;
            fin = int'(last) + int'(cfg_margin);
            if (fin > lim)
                fin = lim;
            seg.last_line = 12'(fin);
        end
        run_on = 1'b0;
        return hit;
    endfunction

    function automatic bit profile_pixel(input logic [7:0] pix, input logic lend,
                                         input logic iend, output t_seg seg);
        logic [12:0] cnt;
        logic [24:0] sum;
        bit hit;
        hit = 1'b0;
        seg = '0;
        if (pix == 8'd0 && dark_cnt < CNT_CAP)
            dark_cnt = dark_cnt + 13'd1;
        if (lend || iend) begin
            cnt = (dark_cnt < cfg_min_line) ? 13'd0 : dark_cnt;
            if (cnt != 13'd0) begin
                if (!run_on) begin
                    run_on = 1'b1;
                    run_first = line_idx;
                    run_mass = 24'(cnt);
                end else begin
                    sum = {1'b0, run_mass} + 25'(cnt);
                    run_mass = (sum > 25'(MASS_MAX)) ? MASS_MAX : sum[23:0];
                end
                if (iend)
                    hit = close_segment(line_idx, seg);
            end else if (run_on) begin
                hit = close_segment((line_idx > 12'd0) ? line_idx - 12'd1 : 12'd0, seg);
            end
            dark_cnt = '0;
            if (iend) begin
                line_idx = '0;
                run_on = 1'b0;
                run_mass = '0;
                run_first = '0;
            end else if (line_idx < IDX_CAP) begin
                line_idx = line_idx + 12'd1;
            end
        end
        return hit;
    endfunction

    // called at a falling edge; leaves tvalid high so back-to-back pixels stream
    task automatic send_pixel(input logic [7:0] pix, input logic lend, input logic iend,
                              input bit typed, input t_seg typed_seg);
        t_seg seg;
        bit hit;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= lend;
        s_axis_tuser  <= iend;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hit = profile_pixel(pix, lend, iend, seg);
        if (typed)
            segs_due = {segs_due, typed_seg};
        else if (hit)
            segs_due = {segs_due, seg};
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line(input int len, input int dark_pct, input logic lend,
                             input logic iend);
        logic [7:0] pix;
        for (int i = 0; i < len; i++) begin
            pix = ($urandom_range(0, 99) < dark_pct) ? 8'd0 : 8'($urandom_range(1, 255));
            send_pixel(pix, lend && (i == len - 1), iend && (i == len - 1), 1'b0, no_seg);
        end
    endtask

    task automatic send_image(input int max_lines, input int max_len);
        int n;
        int pct;
        n = $urandom_range(1, max_lines);
        for (int k = 0; k < n; k++) begin
            pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(50, 100);
            if (k == n - 1)
                send_line($urandom_range(1, max_len), pct, 1'($urandom_range(0, 1)), 1'b1);
            else
                send_line($urandom_range(1, max_len), pct, 1'b1, 1'b0);
        end
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_pixel(($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom),
                       $urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0,
                       1'b0, no_seg);
    endtask

    // hold the sender until every segment has come back, then let the pipe settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < 5000 && segs_due.size() != 0; n++)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [31:0] value, input int width);
        logic [31:0] mask;
        logic [31:0] word;
        mask = (width >= 32) ? 32'hFFFFFFFF : ((32'd1 << width) - 32'd1);
        word = ($urandom & ~mask) | (value & mask);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_MIN_LINE_COUNT: cfg_min_line = word[12:0];
            REG_MIN_RUN_MASS:   cfg_min_mass = word[23:0];
            REG_MARGIN:         cfg_margin   = word[7:0];
            REG_LINE_TOTAL:     cfg_lines    = word[12:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [12:0] min_line, input logic [23:0] min_mass,
                              input logic [7:0] margin, input logic [12:0] lines);
        wait_idle();
        cfg_write(REG_MIN_LINE_COUNT, 32'(min_line), 13);
        cfg_write(REG_MIN_RUN_MASS, 32'(min_mass), 24);
        cfg_write(REG_MARGIN, 32'(margin), 8);
        cfg_write(REG_LINE_TOTAL, 32'(lines), 13);
        // an index past the register list must be dropped
        cfg_write(8'($urandom_range(4, 255)), $urandom, 0);
    endtask

    task automatic run_phase(input t_phase ph, input int quota);
        int start_cnt;
        set_config(ph.min_line, ph.min_mass, ph.margin, ph.lines);
        start_cnt = pixels_sent;
        while (pixels_sent - start_cnt < quota) begin
            if ($urandom_range(0, 9) == 0)
                send_noise($urandom_range(1, 8));
            else
                send_image(ph.max_lines, ph.max_len);
        end
    endtask

    // result side: random stall bursts until the final phase
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_seg want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (segs_due.size() == 0) begin
                report_error($sformatf("unexpected segment %0d..%0d",
                                       m_axis_tdata[11:0], m_axis_tdata[23:12]));
            end else begin
                want = segs_due.pop_front();
                segs_checked++;
                if (m_axis_tdata[11:0] !== want.first_line)
                    report_error($sformatf("seg_start %0d, expected %0d",
                                           m_axis_tdata[11:0], want.first_line));
                if (m_axis_tdata[23:12] !== want.last_line)
                    report_error($sformatf("seg_finish %0d, expected %0d",
                                           m_axis_tdata[23:12], want.last_line));
            end
        end
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_config(13'd1, 24'd1, 8'd1, 13'd5);
        cfg_write(8'hFF, 32'hFFFFFFFF, 0);
        foreach (plan[r])
            send_pixel(plan[r].pix, plan[r].lend, plan[r].iend, plan[r].typed,
                       '{plan[r].first_line, plan[r].last_line});

        for (int p = 0; p < 6; p++)
            run_phase(phases[p], 93);

        wait_idle();
        calm = 1'b1;
        run_phase(phases[6], 93);

        wait_idle();
        repeat (20) @(negedge i_clk);
        while (segs_due.size() != 0) begin
            report_error("segment never arrived");
            void'(segs_due.pop_front());
        end

        $display("sent %0d pixels across directed rows and 7 random register settings",
                 pixels_sent);
        $display("compared %0d segments, %0d mismatches", segs_checked, errors);
        if (errors == 0)
            $display("projection_profile_segmenter_top_tb passed");
        else
            $display("projection_profile_segmenter_top_tb failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("projection_profile_segmenter_top_tb failed");
        $finish;
    end

endmodule

// ===== projection_profile_segmenter_top.f =====
+incdir+rtl/core
rtl/core/ppseg_pkg.sv
rtl/core/ppseg_front.sv
rtl/core/ppseg_queue.sv
rtl/core/ppseg_back.sv
rtl/core/projection_profile_segmenter_top.sv
tb/projection_profile_segmenter_top_tb.sv
